/* hw/rtl/assert_macros.svh */
// Assertion macros, used by text_terminal_cell_buffer.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/tcb_pkg.sv */
// Shared types and constants of the text terminal cell buffer.
// No dependencies.
package tcb_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 70;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 7;
  localparam int ADDR_W   = $clog2(CELLS);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam char_t SPACE_CHAR      = 8'h20;
  localparam char_t DEL_CHAR        = 8'd127;
  localparam char_t BS_CHAR         = 8'd8;
  localparam char_t CR_CHAR         = 8'd13;
  localparam char_t LF_CHAR         = 8'd10;
  localparam char_t FIRST_PRINTABLE = 8'd32;

  localparam pos_t  LAST_ROW      = POS_W'(ROWS - 1);
  localparam pos_t  LAST_COL      = POS_W'(COLUMNS - 1);
  localparam addr_t LAST_CELL     = ADDR_W'(CELLS - 1);
  localparam addr_t ROW_LAST_CELL = ADDR_W'(COLUMNS - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_BLANK,
    ST_CLEAR,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic rd_capture;
    logic push;
  } tcb_cmd_t;

  typedef struct packed {
    action_t action;
    logic    scroll_needed;
    logic    sweep_last;
    logic    out_free;
  } tcb_stat_t;

endpackage

/* hw/rtl/tcb_in_if.sv */
// Request channel of the text terminal cell buffer: valid/ready plus command fields.
// Depends on tcb_pkg.
interface tcb_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcb_pkg::ACTION_W-1:0]  action;
  logic [tcb_pkg::CHAR_W-1:0]    char_code;
  logic [tcb_pkg::POS_W-1:0]     read_row;
  logic [tcb_pkg::POS_W-1:0]     read_col;

  modport source (output valid, output action, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input action, input char_code, input read_row,
                  input read_col, output ready);
endinterface

/* hw/rtl/tcb_out_if.sv */
// Result channel of the text terminal cell buffer: valid/ready plus result fields.
// Depends on tcb_pkg.
interface tcb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        cell_written;
  logic [tcb_pkg::POS_W-1:0]   cell_row;
  logic [tcb_pkg::POS_W-1:0]   cell_col;
  logic [tcb_pkg::CHAR_W-1:0]  cell_char;
  logic                        scrolled;
  logic                        screen_cleared;
  logic [tcb_pkg::POS_W-1:0]   cursor_row;
  logic [tcb_pkg::POS_W-1:0]   cursor_col;
  logic [tcb_pkg::CHAR_W-1:0]  read_char;

  modport source (output valid, output cell_written, output cell_row, output cell_col,
                  output cell_char, output scrolled, output screen_cleared,
                  output cursor_row, output cursor_col, output read_char, input ready);
  modport sink   (input valid, input cell_written, input cell_row, input cell_col,
                  input cell_char, input scrolled, input screen_cleared,
                  input cursor_row, input cursor_col, input read_char, output ready);
endinterface

/* hw/rtl/text_terminal_cell_buffer.sv */
// Text terminal cell buffer: 70 x 80 character grid with cursor and ring-pointer scroll.
// Requests on in_ch: action 0 puts char_code at the cursor (CR, LF, backspace/DEL
// handled, other control bytes dropped), action 1 clears the screen, action 2 reads
// the cell at read_row/read_col. Every request gives exactly one result on out_ch.
// One request is in work at a time; in_ch.ready is high only while the block idles.
// Steps from acceptance to a result in the output register:
//   put without scroll, no-op action: execute, then hand off
//   read: execute, a wait for the registered cell store read port, hand off
//   put that scrolls: execute, blank the new bottom row one cell per cycle, hand off
//   clear: execute, blank the whole store one cell per cycle, hand off
// The cell store is single-port: one address serves its write and its registered read.
// After reset the block blanks all 5600 cells with in_ch.ready low.
// The result sits in an output register; while out_ch stalls it holds, and the block
// waits to hand off the next result, with in_ch.ready low, until the register is taken.
// Depends on tcb_pkg, tcb_in_if, tcb_out_if, tcb_ctrl, tcb_datapath, assert_macros.svh.
`include "assert_macros.svh"
module text_terminal_cell_buffer (
  input  logic      clk,
  input  logic      rst_n,
  tcb_in_if.sink    in_ch,
  tcb_out_if.source out_ch
);
  import tcb_pkg::*;

  tcb_cmd_t  cmd;
  tcb_stat_t stat;
  logic      ctrl_ready;

  tcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcb_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_ch.action),
    .in_char_code (in_ch.char_code),
    .in_read_row  (in_ch.read_row),
    .in_read_col  (in_ch.read_col),
    .out_ch       (out_ch)
  );

  assign in_ch.ready = ctrl_ready;

  `ASSERT_IMP(a_push_needs_room, cmd.push, stat.out_free)
  `ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMP(a_cursor_in_grid, out_ch.valid,
              (out_ch.cursor_row <= LAST_ROW) && (out_ch.cursor_col <= LAST_COL))
  `ASSERT_IMP(a_scroll_cursor, out_ch.valid && out_ch.scrolled,
              (out_ch.cursor_row == LAST_ROW) && (out_ch.cursor_col == '0))

endmodule

/* hw/rtl/tcb_ctrl.sv */
// Sequencing state machine of the text terminal cell buffer.
// Depends on tcb_pkg; drives the datapath through tcb_cmd_t.
module tcb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcb_pkg::tcb_stat_t stat,
  output tcb_pkg::tcb_cmd_t  cmd
);
  import tcb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.action)
          ACT_PUT:   state_nxt = stat.scroll_needed ? ST_BLANK : ST_PUSH;
          ACT_CLEAR: state_nxt = ST_CLEAR;
          ACT_READ:  state_nxt = ST_RD_WAIT;
          default:   state_nxt = ST_PUSH;
        endcase
      end
      ST_RD_WAIT: state_nxt = ST_PUSH;
      ST_BLANK, ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_INIT:    cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC:    cmd.exec = 1'b1;
      ST_RD_WAIT: cmd.rd_capture = 1'b1;
      ST_BLANK,
      ST_CLEAR:   cmd.sweep = 1'b1;
      ST_PUSH:    cmd.push = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/tcb_datapath.sv */
// Cell store, cursor, ring pointer, blanking sweep and result register.
// Depends on tcb_pkg and tcb_out_if; commanded by tcb_ctrl.
module tcb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  tcb_pkg::tcb_cmd_t  cmd,
  output tcb_pkg::tcb_stat_t stat,
  input  logic [tcb_pkg::ACTION_W-1:0] in_action,
  input  tcb_pkg::char_t     in_char_code,
  input  tcb_pkg::pos_t      in_read_row,
  input  tcb_pkg::pos_t      in_read_col,
  tcb_out_if.source          out_ch
);
  import tcb_pkg::*;

  char_t mem [CELLS];
  char_t mem_q_r;

  // latched request
  action_t act_r, act_nxt;
  char_t   ch_r, ch_nxt;
  pos_t    rr_r, rr_nxt;
  pos_t    rc_r, rc_nxt;

  // architectural state
  pos_t  row_r, row_nxt;
  pos_t  col_r, col_nxt;
  pos_t  top_r, top_nxt;

  // blanking sweep
  addr_t sw_cnt_r, sw_cnt_nxt;
  addr_t sw_base_r, sw_base_nxt;
  addr_t sw_last_r, sw_last_nxt;

  // pending result
  logic  res_written_r, res_written_nxt;
  pos_t  res_wrow_r, res_wrow_nxt;
  pos_t  res_wcol_r, res_wcol_nxt;
  char_t res_wchar_r, res_wchar_nxt;
  logic  res_scrolled_r, res_scrolled_nxt;
  logic  res_cleared_r, res_cleared_nxt;
  char_t res_rchar_r, res_rchar_nxt;
  logic  in_range_r, in_range_nxt;

  // output register
  logic  out_valid_r, out_valid_nxt;
  logic  o_written_r, o_scrolled_r, o_cleared_r;
  pos_t  o_wrow_r, o_wcol_r, o_crow_r, o_ccol_r;
  char_t o_wchar_r, o_rchar_r;

  logic  is_print, is_bs, is_lf, at_last_row, wrap, erase_ok, scroll_needed;
  pos_t  t_row, t_col;
  logic [POS_W:0] phys_sum;
  pos_t  phys_row;
  addr_t cell_addr, top_base, mem_addr;
  logic  mem_we;
  char_t mem_wdata;

  assign is_print    = (ch_r >= FIRST_PRINTABLE) && (ch_r != DEL_CHAR);
  assign is_bs       = (ch_r == BS_CHAR) || (ch_r == DEL_CHAR);
  assign is_lf       = (ch_r == LF_CHAR);
  assign at_last_row = (row_r == LAST_ROW);
  assign wrap        = (col_r == LAST_COL);
  assign erase_ok    = is_bs && (col_r != '0);
  assign scroll_needed = (act_r == ACT_PUT) && at_last_row && (is_lf || (is_print && wrap));

  // logical to physical cell address through the ring pointer
  always_comb begin
    if (act_r == ACT_READ) begin
      t_row = rr_r;
      t_col = rc_r;
    end else if (erase_ok) begin
      t_row = row_r;
      t_col = col_r - 1'b1;
    end else begin
      t_row = row_r;
      t_col = col_r;
    end
  end

  assign phys_sum  = {1'b0, top_r} + {1'b0, t_row};
  assign phys_row  = (phys_sum >= (POS_W+1)'(ROWS)) ? POS_W'(phys_sum - (POS_W+1)'(ROWS))
                                                    : POS_W'(phys_sum);
  assign cell_addr = addr_t'(phys_row) * addr_t'(COLUMNS) + addr_t'(t_col);
  assign top_base  = addr_t'(top_r) * addr_t'(COLUMNS);

  assign mem_addr  = cmd.sweep ? (sw_base_r + sw_cnt_r) : cell_addr;
  assign mem_we    = cmd.sweep ||
                     (cmd.exec && (act_r == ACT_PUT) && !is_lf && (is_print || erase_ok));
  assign mem_wdata = (cmd.sweep || !is_print) ? SPACE_CHAR : ch_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q_r <= mem[mem_addr];
  end

  always_comb begin
    act_nxt = act_r;
    ch_nxt  = ch_r;
    rr_nxt  = rr_r;
    rc_nxt  = rc_r;
    row_nxt = row_r;
    col_nxt = col_r;
    top_nxt = top_r;
    sw_cnt_nxt  = sw_cnt_r;
    sw_base_nxt = sw_base_r;
    sw_last_nxt = sw_last_r;
    res_written_nxt  = res_written_r;
    res_wrow_nxt     = res_wrow_r;
    res_wcol_nxt     = res_wcol_r;
    res_wchar_nxt    = res_wchar_r;
    res_scrolled_nxt = res_scrolled_r;
    res_cleared_nxt  = res_cleared_r;
    res_rchar_nxt    = res_rchar_r;
    in_range_nxt     = in_range_r;

    if (cmd.accept) begin
      act_nxt = action_t'(in_action);
      ch_nxt  = in_char_code;
      rr_nxt  = in_read_row;
      rc_nxt  = in_read_col;
    end

    if (cmd.exec) begin
      res_written_nxt  = 1'b0;
      res_wrow_nxt     = '0;
      res_wcol_nxt     = '0;
      res_wchar_nxt    = '0;
      res_scrolled_nxt = 1'b0;
      res_cleared_nxt  = 1'b0;
      res_rchar_nxt    = '0;
      case (act_r)
        ACT_PUT: begin
          if (ch_r == CR_CHAR) begin
            col_nxt = '0;
          end else if (is_lf) begin
            col_nxt = '0;
            if (!at_last_row) row_nxt = row_r + 1'b1;
          end else if (is_bs) begin
            if (erase_ok) begin
              col_nxt         = col_r - 1'b1;
              res_written_nxt = 1'b1;
              res_wrow_nxt    = row_r;
              res_wcol_nxt    = col_r - 1'b1;
              res_wchar_nxt   = SPACE_CHAR;
            end
          end else if (is_print) begin
            res_written_nxt = 1'b1;
            // a wrap that scrolls moves the written cell one row up
            res_wrow_nxt    = (wrap && at_last_row) ? row_r - 1'b1 : row_r;
            res_wcol_nxt    = col_r;
            res_wchar_nxt   = ch_r;
            if (wrap) begin
              col_nxt = '0;
              if (!at_last_row) row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          if (scroll_needed) begin
            // blank the old top row, then it becomes the bottom row
            res_scrolled_nxt = 1'b1;
            top_nxt     = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
            sw_base_nxt = top_base;
            sw_cnt_nxt  = '0;
            sw_last_nxt = ROW_LAST_CELL;
          end
        end
        ACT_CLEAR: begin
          res_cleared_nxt = 1'b1;
          top_nxt     = '0;
          row_nxt     = '0;
          col_nxt     = '0;
          sw_base_nxt = '0;
          sw_cnt_nxt  = '0;
          sw_last_nxt = LAST_CELL;
        end
        ACT_READ: begin
          in_range_nxt = ({1'b0, rr_r} < (POS_W+1)'(ROWS)) &&
                         ({1'b0, rc_r} < (POS_W+1)'(COLUMNS));
        end
        default: ;
      endcase
    end

    if (cmd.sweep) sw_cnt_nxt = sw_cnt_r + 1'b1;
    if (cmd.rd_capture) res_rchar_nxt = in_range_r ? mem_q_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      sw_cnt_r    <= '0;
      sw_base_r   <= '0;
      sw_last_r   <= LAST_CELL;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_base_r   <= sw_base_nxt;
      sw_last_r   <= sw_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r          <= act_nxt;
    ch_r           <= ch_nxt;
    rr_r           <= rr_nxt;
    rc_r           <= rc_nxt;
    res_written_r  <= res_written_nxt;
    res_wrow_r     <= res_wrow_nxt;
    res_wcol_r     <= res_wcol_nxt;
    res_wchar_r    <= res_wchar_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    res_cleared_r  <= res_cleared_nxt;
    res_rchar_r    <= res_rchar_nxt;
    in_range_r     <= in_range_nxt;
    if (cmd.push) begin
      o_written_r  <= res_written_r;
      o_wrow_r     <= res_wrow_r;
      o_wcol_r     <= res_wcol_r;
      o_wchar_r    <= res_wchar_r;
      o_scrolled_r <= res_scrolled_r;
      o_cleared_r  <= res_cleared_r;
      o_crow_r     <= row_r;
      o_ccol_r     <= col_r;
      o_rchar_r    <= res_rchar_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.action        = act_r;
  assign stat.scroll_needed = scroll_needed;
  assign stat.sweep_last    = (sw_cnt_r == sw_last_r);
  assign stat.out_free      = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_written   = o_written_r;
  assign out_ch.cell_row       = o_wrow_r;
  assign out_ch.cell_col       = o_wcol_r;
  assign out_ch.cell_char      = o_wchar_r;
  assign out_ch.scrolled       = o_scrolled_r;
  assign out_ch.screen_cleared = o_cleared_r;
  assign out_ch.cursor_row     = o_crow_r;
  assign out_ch.cursor_col     = o_ccol_r;
  assign out_ch.read_char      = o_rchar_r;

endmodule
